### hw/rtl/iafr_pkg.sv
// Shared constants, types and the angle scaling function for the IMU angle
// frame receiver. No dependencies.
package iafr_pkg;

    localparam int BYTE_W         = 8;
    localparam int RAW_W          = 16;
    localparam int DEG_W          = 24;
    localparam int FRAME_LEN_DEF  = 11;
    localparam int ANGLE_BYTES    = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int OUT_DATA_W     = 3 * DEG_W;

    localparam logic [BYTE_W-1:0] HEADER_RST     = 8'h55;
    localparam logic [BYTE_W-1:0] ANGLE_TYPE_RST = 8'h53;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER     = 2'd0,
        REG_ANGLE_TYPE = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] angle_type;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        logic signed [RAW_W-1:0] roll;
        logic signed [RAW_W-1:0] pitch;
        logic signed [RAW_W-1:0] yaw;
    } angle_cap_t;

    // x * 180 as shifts and adds: 180 = 128 + 32 + 16 + 4
    function automatic logic signed [DEG_W-1:0] scale_deg(input logic signed [RAW_W-1:0] x);
        logic signed [DEG_W-1:0] sx;
        sx = DEG_W'(x);
        return (sx <<< 7) + (sx <<< 5) + (sx <<< 4) + (sx <<< 2);
    endfunction

endpackage

### hw/rtl/imu_angle_frame_receiver_core.sv
// Top level of the IMU angle frame receiver: configuration registers,
// frame buffer and angle scaling. Depends on iafr_pkg, iafr_frame_buf,
// iafr_angle_scale.
//
// Usage
//   s_* : one received serial byte per beat (s_tdata = rx_byte).
//   m_* : one beat per completed angle packet, roll/pitch/yaw in degrees
//         times 32768 as 24-bit two's complement.
//   cfg : header byte (index 0) and angle type byte (index 1), written while
//         the block is idle; other indexes are ignored.
//   A header byte restarts the frame at any point. After FRAME_LEN bytes the
//   frame closes; if it starts with the header and angle type bytes, a
//   result beat follows.
//   Timing: the capture register loads when the last byte is accepted; the
//   output register loads from it when the output stage advances, and the
//   result beat is offered from the output register until it is taken.
//   Throughput: one byte per cycle while s_tready is high; the frame
//   position update and packet match are one compare stage per byte.
//   Reset: position returns to the start of a frame, configuration goes to
//   0x55 / 0x53, no result is pending.
//   Stall: with m_tready low, a frame completed behind the held output beat
//   waits in the capture register and s_tready stays low while it waits,
//   until the output beat is taken.
module imu_angle_frame_receiver_core #(
    parameter int FRAME_LEN = iafr_pkg::FRAME_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [iafr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [iafr_pkg::BYTE_W-1:0]         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [iafr_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [iafr_pkg::OUT_DATA_W-1:0]     m_tdata    // [23:0] roll_deg,
                                                            // [47:24] pitch_deg,
                                                            // [71:48] yaw_deg
);
    import iafr_pkg::*;

    cfg_t       cfg_reg;
    logic       accept, advance, cap_load;
    angle_cap_t cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header     <= HEADER_RST;
            cfg_reg.angle_type <= ANGLE_TYPE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER:     cfg_reg.header     <= cfg_wdata;
                REG_ANGLE_TYPE: cfg_reg.angle_type <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign s_tready = !cap.valid || advance;
    assign accept   = s_tvalid && s_tready;

    iafr_frame_buf #(
        .FRAME_LEN (FRAME_LEN)
    ) u_frame_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .rx_byte  (s_tdata),
        .advance  (advance),
        .cap_load (cap_load),
        .cap      (cap)
    );

    iafr_angle_scale u_angle_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap),
        .advance   (advance),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTH
    // a header byte always reopens a frame, so it can never complete one
    a_header_no_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tdata == cfg_reg.header) |-> !cap_load)
        else $error("frame completed on a header byte");

    // a completed frame is held until the output stage takes it
    a_capture_held: assert property (@(posedge clk) disable iff (!rst_n)
        cap_load |=> cap.valid)
        else $error("captured angles lost");

    // full capture behind a stalled output must stop intake
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (cap.valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted with capture and output both full");
`endif

endmodule

### hw/rtl/iafr_frame_buf.sv
// Frame assembly: write position, stored angle bytes, header resync and
// angle packet match; captures the raw angles of a completed, matching frame.
// Depends on iafr_pkg.
module iafr_frame_buf #(
    parameter int FRAME_LEN = iafr_pkg::FRAME_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  iafr_pkg::cfg_t                cfg,
    input  logic                          accept,
    input  logic [iafr_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                          advance,
    output logic                          cap_load,
    output iafr_pkg::angle_cap_t          cap
);
    import iafr_pkg::*;

    localparam int POS_W = $clog2(FRAME_LEN);

    logic [POS_W-1:0]  pos_reg, pos_next, pos_eff;
    logic [BYTE_W-1:0] store_reg [ANGLE_BYTES];
    logic [BYTE_W-1:0] byte_cur  [ANGLE_BYTES];
    logic              start, last, match;
    logic              cap_valid_reg, cap_valid_next;
    logic signed [RAW_W-1:0] roll_reg, pitch_reg, yaw_reg;

    always_comb
    begin
        start   = (rx_byte == cfg.header);
        pos_eff = start ? '0 : pos_reg;
        for (int i = 0; i < ANGLE_BYTES; i++)
        begin
            byte_cur[i] = (pos_eff == POS_W'(i)) ? rx_byte : store_reg[i];
        end
        last     = (pos_eff == POS_W'(FRAME_LEN - 1));
        pos_next = last ? '0 : pos_eff + POS_W'(1);
        match    = (byte_cur[0] == cfg.header) && (byte_cur[1] == cfg.angle_type);
        cap_load = accept && last && match;
        if (cap_load)
            cap_valid_next = 1'b1;
        else if (advance)
            cap_valid_next = 1'b0;
        else
            cap_valid_next = cap_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                pos_reg <= pos_next;
            cap_valid_reg <= cap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < ANGLE_BYTES; i++)
            begin
                store_reg[i] <= byte_cur[i];
            end
        end
        if (cap_load)
        begin
            roll_reg  <= {byte_cur[3], byte_cur[2]};
            pitch_reg <= {byte_cur[5], byte_cur[4]};
            yaw_reg   <= {byte_cur[7], byte_cur[6]};
        end
    end

    assign cap.valid = cap_valid_reg;
    assign cap.roll  = roll_reg;
    assign cap.pitch = pitch_reg;
    assign cap.yaw   = yaw_reg;

endmodule

### hw/rtl/iafr_angle_scale.sv
// Scales captured raw angles to degrees in signed Q8.15 and holds them in the output
// register until the beat is taken. Depends on iafr_pkg.
module iafr_angle_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  iafr_pkg::angle_cap_t              cap,
    output logic                              advance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [iafr_pkg::OUT_DATA_W-1:0]   out_data
);
    import iafr_pkg::*;

    logic                    valid_reg;
    logic signed [DEG_W-1:0] roll_reg, pitch_reg, yaw_reg;

    assign advance = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= cap.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && cap.valid)
        begin
            roll_reg  <= scale_deg(cap.roll);
            pitch_reg <= scale_deg(cap.pitch);
            yaw_reg   <= scale_deg(cap.yaw);
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {yaw_reg, pitch_reg, roll_reg};

endmodule
